### rtl/pckr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: shared package
// Word layouts, codes, controller states and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pckr_pkg;

  localparam int BINS     = 256;
  localparam int BIN_W    = 8;
  localparam int PERIOD_W = 6;
  localparam int COLUMN_W = 5;

  // Printable-text offset that is taken off the most frequent byte.
  localparam logic [BIN_W-1:0] KEY_OFFSET = 8'd32;

  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [BIN_W-1:0] cipher_byte;
  } in_word_t;

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [BIN_W-1:0]    key_byte;
    logic                key_valid;
    logic                last;
  } out_word_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_FINAL = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic scan_rd;
    logic clr_wr;
    logic addr_inc;
    logic addr_clr;
    logic res_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fin_accept;
    logic bin_last;
    logic col_last;
    logic col_final;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/pckr_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: stream channel
// Valid/ready channel that carries one word of the given payload type.
// ----------------------------------------------------------------------------
interface pckr_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

### rtl/pckr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pckr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/pckr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: controller
// Sequences the clearing sweep, the per-column histogram scan and the
// hand-off of each column's result to the output register.
// ----------------------------------------------------------------------------
module pckr_ctrl import pckr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.col_final && status_i.bin_last) begin
          cmd_o.addr_clr = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.addr_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (status_i.fin_accept) begin
          cmd_o.addr_clr = 1'b1;
          state_d        = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        // The address stays on the last bin so the column is still known at emit.
        if (status_i.bin_last) begin
          state_d = ST_FINAL;
        end else begin
          cmd_o.addr_inc = 1'b1;
        end
      end
      ST_FINAL: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.res_load = 1'b1;
          if (!status_i.col_last) begin
            cmd_o.addr_inc = 1'b1;
            state_d        = ST_SCAN;
          end else if (status_i.col_final) begin
            cmd_o.addr_clr = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            // Columns above the period may still hold counts; wipe them too.
            cmd_o.addr_inc = 1'b1;
            state_d        = ST_CLEAR;
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

### rtl/pckr_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: datapath
// Period register, column counter, histogram RAM with a forwarded
// read-modify-write for byte words, the argmax scan and the output register.
// ----------------------------------------------------------------------------
module pckr_dpath import pckr_pkg::*; #(
  parameter int MAX_PERIOD  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_status_t          status_o,
  pckr_stream_if.sink         in_if,
  pckr_stream_if.source       out_if
);

  localparam int CW     = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int AW     = CW + BIN_W;
  localparam int DEPTH  = MAX_PERIOD * BINS;
  localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW1    = PERIOD_W + 1;

  localparam logic [PW1-1:0]         MAX_P     = PW1'(MAX_PERIOD);
  localparam logic [CW-1:0]          LAST_COL  = CW'(MAX_PERIOD - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [PERIOD_W-1:0] period_q;
  logic [PW1-1:0]      act_period;

  logic [CW-1:0]  col_q, col_d;
  logic [PW1-1:0] col_inc;

  logic [AW-1:0]    scan_addr_q, scan_addr_d;
  logic [CW-1:0]    scan_col;
  logic [BIN_W-1:0] scan_bin;

  logic in_acc, byte_acc, fin_acc;

  logic                   ram_we;
  logic [RAM_AW-1:0]      ram_waddr, ram_raddr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  logic                   byte_v_q;
  logic [AW-1:0]          byte_addr_q;
  logic                   fwd_v_q;
  logic [AW-1:0]          fwd_addr_q;
  logic [COUNT_WIDTH-1:0] fwd_cnt_q;
  logic [COUNT_WIDTH-1:0] cur_cnt, new_cnt;

  logic                   rd_v_q;
  logic [AW-1:0]          rd_addr_q;
  logic [COUNT_WIDTH-1:0] best_cnt_q;
  logic [BIN_W-1:0]       best_bin_q;
  logic                   tied_q;

  logic      out_v_q;
  out_word_t out_q;
  logic      col_last;

  // Period zero counts as one; anything above the column count saturates.
  always_comb begin
    if (period_q == '0) begin
      act_period = PW1'(1);
    end else if ({1'b0, period_q} > MAX_P) begin
      act_period = MAX_P;
    end else begin
      act_period = {1'b0, period_q};
    end
  end

  assign in_if.ready = cmd_i.in_ready;
  assign in_acc      = in_if.valid && cmd_i.in_ready;
  assign byte_acc    = in_acc && (in_if.payload.kind == KIND_BYTE);
  assign fin_acc     = in_acc && (in_if.payload.kind == KIND_FINISH);

  assign col_inc = PW1'(col_q) + PW1'(1);

  always_comb begin
    col_d = col_q;
    if (fin_acc) begin
      col_d = '0;
    end else if (byte_acc) begin
      col_d = (col_inc >= act_period) ? '0 : CW'(col_inc);
    end
  end

  always_comb begin
    scan_addr_d = scan_addr_q;
    if (cmd_i.addr_clr) begin
      scan_addr_d = '0;
    end else if (cmd_i.addr_inc) begin
      scan_addr_d = scan_addr_q + AW'(1);
    end
  end

  assign scan_col = scan_addr_q[AW-1:BIN_W];
  assign scan_bin = scan_addr_q[BIN_W-1:0];
  assign col_last = ((PW1'(scan_col) + PW1'(1)) == act_period);

  assign status_o.fin_accept = fin_acc;
  assign status_o.bin_last   = (scan_bin == '1);
  assign status_o.col_last   = col_last;
  assign status_o.col_final  = (scan_col == LAST_COL);
  assign status_o.out_free   = !out_v_q || out_if.ready;

  assign ram_raddr = cmd_i.scan_rd ? RAM_AW'(scan_addr_q)
                                   : RAM_AW'({col_q, in_if.payload.cipher_byte});

  // A byte that hits the bin written by the byte just ahead of it takes the written count,
  // since the RAM returns the old contents on a same-edge read.
  assign cur_cnt = (fwd_v_q && (fwd_addr_q == byte_addr_q)) ? fwd_cnt_q : ram_rdata;
  assign new_cnt = (cur_cnt == COUNT_MAX) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = RAM_AW'(scan_addr_q);
    ram_wdata = '0;
    priority if (byte_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = RAM_AW'(byte_addr_q);
      ram_wdata = new_cnt;
    end else if (rd_v_q) begin
      ram_we    = 1'b1;
      ram_waddr = RAM_AW'(rd_addr_q);
    end else if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
    end
  end

  pckr_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (DEPTH)
  ) u_hist (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= PERIOD_W'(1);
      col_q       <= '0;
      scan_addr_q <= '0;
      byte_v_q    <= 1'b0;
      fwd_v_q     <= 1'b0;
      rd_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        period_q <= cfg_data_i;
      end
      col_q       <= col_d;
      scan_addr_q <= scan_addr_d;
      byte_v_q    <= byte_acc;
      fwd_v_q     <= byte_v_q;
      rd_v_q      <= cmd_i.scan_rd;
      if (cmd_i.res_load) begin
        out_v_q <= 1'b1;
      end else if (out_if.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byte_addr_q <= {col_q, in_if.payload.cipher_byte};
    fwd_addr_q  <= byte_addr_q;
    fwd_cnt_q   <= new_cnt;
    rd_addr_q   <= scan_addr_q;
    if (rd_v_q) begin
      if (rd_addr_q[BIN_W-1:0] == '0) begin
        best_cnt_q <= ram_rdata;
        best_bin_q <= '0;
        tied_q     <= 1'b0;
      end else if (ram_rdata > best_cnt_q) begin
        best_cnt_q <= ram_rdata;
        best_bin_q <= rd_addr_q[BIN_W-1:0];
        tied_q     <= 1'b0;
      end else if (ram_rdata == best_cnt_q) begin
        tied_q <= 1'b1;
      end
    end
    if (cmd_i.res_load) begin
      out_q.column    <= COLUMN_W'(scan_col);
      out_q.key_byte  <= best_bin_q - KEY_OFFSET;
      out_q.key_valid <= !tied_q;
      out_q.last      <= col_last;
    end
  end

  assign out_if.valid   = out_v_q;
  assign out_if.payload = out_q;

endmodule

### rtl/periodic_column_key_recovery.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: top level
// Per-column byte histograms with argmax key extraction on a finish word.
// ----------------------------------------------------------------------------
// A ciphertext byte word is taken every cycle while the block is idle; its
// count update is a read-modify-write of the histogram RAM with forwarding
// between back-to-back bytes. A finish word scans the histogram RAM through its
// single read port, one bin per cycle: each active column, once the output
// register is free, yields one result word, and the scan clears each bin it
// reads. Columns at and above the period are then wiped at one entry per
// cycle. After reset the block runs a clearing pass over the whole histogram
// RAM before it accepts its first word; period writes are taken at any time.
module periodic_column_key_recovery import pckr_pkg::*; #(
  parameter int MAX_PERIOD  = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PERIOD_W-1:0] cfg_data_i,
  pckr_stream_if.sink         in_if,
  pckr_stream_if.source       out_if
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pckr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  pckr_dpath #(
    .MAX_PERIOD  (MAX_PERIOD),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_if      (in_if),
    .out_if     (out_if)
  );

endmodule

### rtl/pckr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module pckr_checker import pckr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_kind_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [COLUMN_W-1:0] out_column_i,
  input logic [BIN_W-1:0]    out_key_byte_i,
  input logic                out_key_valid_i,
  input logic                out_last_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // A stalled result word keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_column_i)
      && $stable(out_key_byte_i) && $stable(out_key_valid_i) && $stable(out_last_i))
    else $error("stalled result word changed");

  // A finish word starts the scan, so no input is taken in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_kind_i == KIND_FINISH) |=> !in_ready_i)
    else $error("input taken right after a finish word");

  // A byte word never makes a result appear.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (in_kind_i == KIND_BYTE) && !out_valid_i |=> !out_valid_i)
    else $error("result appeared after a byte word");

  // Results are only loaded while the input side is held off by a scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result loaded while idle");

endmodule

bind periodic_column_key_recovery pckr_checker u_pckr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_if.valid),
  .in_ready_i      (in_if.ready),
  .in_kind_i       (in_if.payload.kind),
  .out_valid_i     (out_if.valid),
  .out_ready_i     (out_if.ready),
  .out_column_i    (out_if.payload.column),
  .out_key_byte_i  (out_if.payload.key_byte),
  .out_key_valid_i (out_if.payload.key_valid),
  .out_last_i      (out_if.payload.last)
);

### tb/sv/periodic_column_key_recovery_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Periodic column key recovery: testbench
// Sends ciphertext byte words and finish words, keeps its own per-column
// histograms and predicts the key word of each column on finish. Every result
// word is checked field by field against the oldest predicted key word.
// ----------------------------------------------------------------------------
module periodic_column_key_recovery_tb import pckr_pkg::*; ();

  localparam int MAX_PERIOD  = 32;
  localparam int COUNT_WIDTH = 16;
  // A finish scans the active columns and wipes every column; leave that much room before a write.
  localparam int QUIET_CYCLES = MAX_PERIOD * BINS + 256;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [PERIOD_W-1:0] cfg_data_i;

  pckr_stream_if #(.payload_t(in_word_t))  in_ch ();
  pckr_stream_if #(.payload_t(out_word_t)) out_ch ();

  periodic_column_key_recovery #(
    .MAX_PERIOD (MAX_PERIOD),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Our copy of the block's state.
  logic [COUNT_WIDTH-1:0] col_hist [MAX_PERIOD][BINS];
  int unsigned            next_column;
  logic [PERIOD_W-1:0]    period_reg;

  out_word_t   key_words_due[$];
  int unsigned mismatches;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  out_word_t   got_word;
  out_word_t   want_word;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("** periodic_column_key_recovery: FAILED **");
    $finish;
  end

  function automatic int unsigned live_period();
    int unsigned p;
    p = 32'(period_reg);
    if (p == 0) p = 1;
    if (p > MAX_PERIOD) p = MAX_PERIOD;
    return p;
  endfunction

  // Counts a byte word, or recovers one key word per column on a finish word.
  task automatic count_or_recover(input in_word_t w);
    int unsigned p;
    int unsigned col;
    int unsigned ties;
    logic [BIN_W-1:0]       best;
    logic [COUNT_WIDTH-1:0] best_n;
    out_word_t              kw;
    p = live_period();
    if (w.kind == KIND_BYTE) begin
      col = next_column % MAX_PERIOD;
      if (col_hist[col][w.cipher_byte] != '1) begin
        col_hist[col][w.cipher_byte]++;
      end
      next_column = (col + 1 >= p) ? 0 : col + 1;
    end else begin
      for (col = 0; col < p; col++) begin
        best   = '0;
        best_n = col_hist[col][0];
        ties   = 1;
        for (int i = 1; i < BINS; i++) begin
          if (col_hist[col][i] > best_n) begin
            best_n = col_hist[col][i];
            best   = i[BIN_W-1:0];
            ties   = 1;
          end else if (col_hist[col][i] == best_n) begin
            ties++;
          end
        end
        kw.column    = col[COLUMN_W-1:0];
        kw.key_byte  = best - KEY_OFFSET;
        kw.key_valid = (ties == 1);
        kw.last      = (col + 1 == p);
        key_words_due = {key_words_due, kw};
      end
      foreach (col_hist[c, b]) col_hist[c][b] = '0;
      next_column = 0;
    end
  endtask

  // Result side: random back-pressure and the field check.
  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got_word = out_ch.payload;
      if (key_words_due.size() == 0) begin
        $error("unexpected key word: column %0d, key_byte %0d",
               got_word.column, got_word.key_byte);
        mismatches++;
      end else begin
        want_word = key_words_due.pop_front();
        check_field("column", 32'(want_word.column), 32'(got_word.column));
        check_field("key_byte", 32'(want_word.key_byte), 32'(got_word.key_byte));
        check_field("key_valid", 32'(want_word.key_valid), 32'(got_word.key_valid));
        check_field("last", 32'(want_word.last), 32'(got_word.last));
      end
    end
  end

  task automatic send_word(input logic kind, input logic [BIN_W-1:0] data);
    in_word_t w;
    w.kind        = kind;
    w.cipher_byte = data;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    count_or_recover(w);
  endtask

  // Holds the sender off until every key word is back and the block is idle.
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (key_words_due.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    period_reg  = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_default();
    // Period is still at its reset value of one.
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_BYTE, 8'hFF);
    send_word(KIND_BYTE, 8'hFF);
    send_word(KIND_FINISH, 8'($urandom_range(255)));
    // The histograms were cleared, so this column is empty.
    send_word(KIND_FINISH, 8'($urandom_range(255)));
    // Tied maximum: the lower byte value wins.
    send_word(KIND_BYTE, 8'h10);
    send_word(KIND_BYTE, 8'h05);
    send_word(KIND_FINISH, 8'hFF);
  endtask

  task automatic test_extreme_periods();
    write_period(6'd32);
    repeat (40) send_word(KIND_BYTE, 8'($urandom_range(255)));
    send_word(KIND_FINISH, 8'h00);
    // Above the column count the period saturates.
    write_period(6'd63);
    repeat (3) send_word(KIND_BYTE, 8'h80);
    send_word(KIND_FINISH, 8'($urandom_range(255)));
    // Zero behaves as a period of one.
    write_period(6'd0);
    send_word(KIND_BYTE, 8'h7F);
    send_word(KIND_BYTE, 8'h7F);
    send_word(KIND_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic test_period_lowered();
    write_period(6'd8);
    repeat (5) send_word(KIND_BYTE, 8'($urandom_range(255)));
    // The column index now sits beyond the new period: used once, then wraps.
    write_period(6'd3);
    repeat (4) send_word(KIND_BYTE, 8'($urandom_range(255)));
    send_word(KIND_FINISH, 8'($urandom_range(255)));
    write_period(6'd8);
    send_word(KIND_FINISH, 8'($urandom_range(255)));
  endtask

  task automatic test_random_text(input int unsigned n_words);
    int unsigned      sent;
    int unsigned      p;
    int unsigned      len;
    logic [BIN_W-1:0] key_text [MAX_PERIOD];
    logic [BIN_W-1:0] plain;
    logic [BIN_W-1:0] data;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(9))
        0:       write_period(6'd0);
        1:       write_period(6'd63);
        2:       write_period(6'd32);
        default: write_period(6'($urandom_range(1, 8)));
      endcase
      p = live_period();
      foreach (key_text[k]) key_text[k] = 8'($urandom_range(255));
      len = $urandom_range(0, 24);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(3) == 0) begin
          data = 8'($urandom_range(255));
        end else begin
          // Text heavy in spaces, so that most columns have a clear maximum.
          plain = ($urandom_range(2) != 0) ? 8'h20 : 8'h61 + 8'($urandom_range(5));
          data  = plain + key_text[i % p];
        end
        send_word(KIND_BYTE, data);
        sent++;
      end
      // Sometimes the text runs on into the next period setting unfinished.
      if ($urandom_range(3) != 0) begin
        send_word(KIND_FINISH, 8'($urandom_range(255)));
        sent++;
        if ($urandom_range(7) == 0) begin
          send_word(KIND_FINISH, 8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_data_i     <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.payload  <= '0;
    mismatches      = 0;
    send_gap_pct    = 14;
    recv_stall_pct  = 83;
    period_reg      = 6'd1;
    next_column     = 0;
    foreach (col_hist[c, b]) col_hist[c][b] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_default();
    test_extreme_periods();
    test_period_lowered();
    test_random_text(25);

    quiesce();
    send_gap_pct   = 83;
    recv_stall_pct = 14;
    test_random_text(25);

    quiesce();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random_text(25);

    quiesce();
    if (mismatches == 0) begin
      $display("** periodic_column_key_recovery: PASSED **");
    end else begin
      $display("** periodic_column_key_recovery: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
rtl/pckr_pkg.sv
rtl/pckr_stream_if.sv
rtl/pckr_ram.sv
rtl/pckr_ctrl.sv
rtl/pckr_dpath.sv
rtl/periodic_column_key_recovery.sv
rtl/pckr_checker.sv
tb/sv/periodic_column_key_recovery_tb.sv
